// ===== design/tlfp_pkg.sv =====
// type-length frame parser package: shared types, codes and reset values
// used by the interfaces, the decode stage and the top level
`default_nettype none

package tlfp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned MASK_W      = 64;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned ERR_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN_TYPE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OTHER_LONG   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_PACKET_LONG  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_UNSUPPORTED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [BYTE_W-1:0] RST_PACKET_TYPE = 8'd1;
  localparam logic [MASK_W-1:0] RST_KNOWN_MASK  = 64'd2;
  localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD = 16'd255;

  typedef enum logic [3:0] {
    PH_TYPE    = 4'b0001,
    PH_LEN_LO  = 4'b0010,
    PH_LEN_HI  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [BYTE_W-1:0]  frame_kind;
    logic [BYTE_W-1:0]  length_low;
    logic [LEN_W-1:0]   expected_length;
    logic [LEN_W-1:0]   payload_count;
  } parse_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packet_type;
    logic [MASK_W-1:0] known_type_mask;
    logic [LEN_W-1:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_out;
    logic [LEN_W-1:0]  frame_length;
    logic              last_byte;
    logic [ERR_W-1:0]  error_code;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_TYPE,
    frame_kind:      '0,
    length_low:      '0,
    expected_length: '0,
    payload_count:   '0
  };

endpackage

`default_nettype wire

// ===== design/tlfp_if.sv =====
// beat channels of the type-length frame parser: byte input and result output
// depends on tlfp_pkg
`default_nettype none

interface tlfp_in_if
  import tlfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tlfp_out_if
  import tlfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_out;
  logic [LEN_W-1:0]  frame_length;
  logic              last_byte;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, output kind, output data_out, output frame_length,
                  output last_byte, output error_code, input ready);
  modport sink (input valid, input kind, input data_out, input frame_length,
                input last_byte, input error_code, output ready);
endinterface

`default_nettype wire

// ===== design/type_length_frame_parser.sv =====
// Type-length frame parser, top level: byte input register, decode stage and result
// register. One byte is accepted every clock cycle while results are taken; each
// result passes from the input register through the decode stage into the result
// register. The rate is set by the single decode stage, which updates the parse state
// for one byte per cycle. Frames are a type byte, a little-endian 16-bit length, then
// the payload; transmit-packet payload bytes stream out with the last one flagged,
// and bad headers or ended non-packet frames give an error beat. The user must write
// configuration (packet type, known-type mask, max payload) only while no bytes are in
// flight; the block does not enforce this. Depends on tlfp_pkg, tlfp_if and tlfp_decode.
`default_nettype none

module type_length_frame_parser
  import tlfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tlfp_in_if.sink                    in_beat,
  tlfp_out_if.source                 out_beat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg_r;
  parse_state_t      state_r;
  parse_state_t      state_nxt;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r;
  result_t           out_r;
  logic              has_result;
  result_t           result;
  logic              s1_adv;
  logic              in_accept;

  assign s1_adv       = !out_valid_r || out_beat.ready;
  assign in_beat.ready = !s1_valid_r || s1_adv;
  assign in_accept    = in_beat.valid && in_beat.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packet_type     <= RST_PACKET_TYPE;
      cfg_r.known_type_mask <= RST_KNOWN_MASK;
      cfg_r.max_payload     <= RST_MAX_PAYLOAD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PACKET_TYPE: cfg_r.packet_type     <= cfg_wdata[BYTE_W-1:0];
        CFG_KNOWN_MASK:  cfg_r.known_type_mask <= cfg_wdata[MASK_W-1:0];
        CFG_MAX_PAYLOAD: cfg_r.max_payload     <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_beat.data_byte;
    end
  end

  tlfp_decode u_decode (
    .state      (state_r),
    .cfg        (cfg_r),
    .data_byte  (s1_byte_r),
    .state_nxt  (state_nxt),
    .has_result (has_result),
    .result     (result)
  );

  // parse state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r && has_result;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r && has_result) begin
      out_r <= result;
    end
  end

  assign out_beat.valid        = out_valid_r;
  assign out_beat.kind         = out_r.kind;
  assign out_beat.data_out     = out_r.data_out;
  assign out_beat.frame_length = out_r.frame_length;
  assign out_beat.last_byte    = out_r.last_byte;
  assign out_beat.error_code   = out_r.error_code;

endmodule

`default_nettype wire

// ===== design/tlfp_decode.sv =====
// per-byte decode: header collection, type and length checks, payload counting
// depends on tlfp_pkg
`default_nettype none

module tlfp_decode
  import tlfp_pkg::*;
(
  input  parse_state_t      state,
  input  cfg_t              cfg,
  input  logic [BYTE_W-1:0] data_byte,
  output parse_state_t      state_nxt,
  output logic              has_result,
  output result_t           result
);

  logic [LEN_W-1:0] hdr_len;
  logic             known;
  logic             is_packet;
  logic [LEN_W-1:0] count_inc;
  logic             is_last;

  assign hdr_len   = {data_byte, state.length_low};
  assign known     = (state.frame_kind[7:6] == 2'b00) &&
                     cfg.known_type_mask[state.frame_kind[5:0]];
  assign is_packet = state.frame_kind == cfg.packet_type;
  assign count_inc = state.payload_count + LEN_W'(1);
  assign is_last   = count_inc >= state.expected_length;

  always_comb begin
    state_nxt  = state;
    has_result = 1'b0;
    result     = '0;
    unique case (state.phase)
      PH_TYPE: begin
        state_nxt.frame_kind = data_byte;
        state_nxt.phase      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        state_nxt.length_low = data_byte;
        state_nxt.phase      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (!known) begin
          has_result          = 1'b1;
          result.kind         = KIND_ERROR;
          result.frame_length = hdr_len;
          result.error_code   = ERR_UNKNOWN_TYPE;
          state_nxt           = STATE_RESET;
        end else if (hdr_len > cfg.max_payload) begin
          has_result          = 1'b1;
          result.kind         = KIND_ERROR;
          result.frame_length = hdr_len;
          result.error_code   = is_packet ? ERR_PACKET_LONG : ERR_OTHER_LONG;
          state_nxt           = STATE_RESET;
        end else if (hdr_len == '0) begin
          has_result = 1'b1;
          if (is_packet) begin
            result.kind      = KIND_EMPTY;
            result.last_byte = 1'b1;
          end else begin
            result.kind       = KIND_ERROR;
            result.error_code = ERR_UNSUPPORTED;
          end
          state_nxt = STATE_RESET;
        end else begin
          state_nxt.expected_length = hdr_len;
          state_nxt.payload_count   = '0;
          state_nxt.length_low      = '0;
          state_nxt.phase           = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        state_nxt.payload_count = count_inc;
        if (is_packet) begin
          has_result          = 1'b1;
          result.kind         = KIND_PAYLOAD;
          result.data_out     = data_byte;
          result.frame_length = state.expected_length;
          result.last_byte    = is_last;
          if (is_last) begin
            state_nxt = STATE_RESET;
          end
        end else if (is_last) begin
          has_result          = 1'b1;
          result.kind         = KIND_ERROR;
          result.frame_length = state.expected_length;
          result.error_code   = ERR_UNSUPPORTED;
          state_nxt           = STATE_RESET;
        end
      end
      default: begin
        state_nxt = STATE_RESET;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sim/tb_type_length_frame_parser.sv =====
// testbench for type_length_frame_parser: drives byte beats, predicts every result beat
// and checks it field by field; directed frames first, then random frames per register setting
// depends on tlfp_pkg, tlfp_in_if, tlfp_out_if and the type_length_frame_parser rtl
`default_nettype none

module tb_type_length_frame_parser
  import tlfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned    BYTE_BUDGET   = 1976;
  localparam int unsigned    QUIET_AT      = BYTE_BUDGET - 250;
  localparam int unsigned    SETTLE_CYCLES = 8;
  localparam int unsigned    CYCLE_LIMIT   = 400000;
  localparam int unsigned    DIR_COUNT     = 26;
  localparam int unsigned    GROUP_B_AT    = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam result_t        NO_RESULT     = '0;

  typedef struct {
    logic [BYTE_W-1:0] b;
    bit                typed;
    result_t           res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tlfp_in_if  in_ch ();
  tlfp_out_if out_ch ();

  type_length_frame_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_ch),
    .out_beat  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies and parse state of the predictor
  logic [BYTE_W-1:0] cfg_pkt_type;
  logic [MASK_W-1:0] cfg_type_mask;
  logic [LEN_W-1:0]  cfg_max_len;
  logic [1:0]        hdr_count;
  logic [BYTE_W-1:0] cur_type;
  logic [BYTE_W-1:0] len_lo;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  pay_count;

  result_t     expected_results[$];
  int unsigned mismatches;
  int unsigned sent_bytes;
  int unsigned cycle_count;
  bit          gaps_on;
  bit          stalls_on;
  bit          quiet;

  stim_row_t dir_rows [DIR_COUNT] = '{
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, '{KIND_ERROR, 8'h00, 16'd256, 1'b0, ERR_PACKET_LONG}},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{KIND_EMPTY, 8'h00, 16'd0, 1'b1, ERR_NONE}},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 16'd1, 1'b1, ERR_NONE}},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h34, 1'b0, NO_RESULT},
    '{8'h12, 1'b1, '{KIND_ERROR, 8'h00, 16'h1234, 1'b0, ERR_UNKNOWN_TYPE}},
    '{8'h40, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{KIND_ERROR, 8'h00, 16'hFFFF, 1'b0, ERR_UNKNOWN_TYPE}},
    '{8'h3E, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{KIND_ERROR, 8'h00, 16'd2, 1'b0, ERR_OTHER_LONG}},
    '{8'h3E, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{KIND_ERROR, 8'h00, 16'd0, 1'b0, ERR_UNSUPPORTED}},
    '{8'h3E, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{KIND_ERROR, 8'h00, 16'd1, 1'b0, ERR_UNSUPPORTED}}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_parser();
    hdr_count = 2'd0;
    cur_type  = '0;
    len_lo    = '0;
    cur_len   = '0;
    pay_count = '0;
  endfunction

  // advances the parse state by one byte; returns 1 when the byte gives a result
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output result_t r);
    logic [LEN_W-1:0] len;
    bit               known;
    bit               is_pkt;
    bit               done;
    r = '0;
    parse_byte = 1'b0;
    case (hdr_count)
      2'd0: begin
        cur_type  = b;
        hdr_count = 2'd1;
      end
      2'd1: begin
        len_lo    = b;
        hdr_count = 2'd2;
      end
      2'd2: begin
        len    = {b, len_lo};
        known  = (cur_type < 8'd64) && cfg_type_mask[cur_type[5:0]];
        is_pkt = (cur_type == cfg_pkt_type);
        parse_byte = 1'b1;
        r.frame_length = len;
        if (!known) begin
          r.kind       = KIND_ERROR;
          r.error_code = ERR_UNKNOWN_TYPE;
        end else if (len > cfg_max_len) begin
          r.kind       = KIND_ERROR;
          r.error_code = is_pkt ? ERR_PACKET_LONG : ERR_OTHER_LONG;
        end else if (len == '0) begin
          if (is_pkt) begin
            r.kind      = KIND_EMPTY;
            r.last_byte = 1'b1;
          end else begin
            r.kind       = KIND_ERROR;
            r.error_code = ERR_UNSUPPORTED;
          end
        end else begin
          parse_byte = 1'b0;
          cur_len    = len;
          pay_count  = '0;
          len_lo     = '0;
          hdr_count  = 2'd3;
        end
        if (parse_byte) clear_parser();
      end
      default: begin
        pay_count = pay_count + 16'd1;
        done = (pay_count >= cur_len);
        r.frame_length = cur_len;
        if (cur_type == cfg_pkt_type) begin
          r.kind      = KIND_PAYLOAD;
          r.data_out  = b;
          r.last_byte = done;
          parse_byte  = 1'b1;
        end else if (done) begin
          r.kind       = KIND_ERROR;
          r.error_code = ERR_UNSUPPORTED;
          parse_byte   = 1'b1;
        end
        if (done) clear_parser();
      end
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_type(input bit want_known);
    logic [BYTE_W-1:0] t;
    for (int k = 0; k < 32; k++) begin
      t = 8'($urandom_range(0, 63));
      if (cfg_type_mask[t[5:0]] == want_known && t != cfg_pkt_type) return t;
    end
    return want_known ? cfg_pkt_type : 8'($urandom_range(64, 255));
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PACKET_TYPE: cfg_pkt_type  = val[BYTE_W-1:0];
      CFG_KNOWN_MASK:  cfg_type_mask = val[MASK_W-1:0];
      CFG_MAX_PAYLOAD: cfg_max_len   = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input result_t typed_res);
    result_t r;
    int      gap;
    if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (parse_byte(b, r)) expected_results.push_back(typed ? typed_res : r);
    sent_bytes++;
    quiet = (sent_bytes >= QUIET_AT);
  endtask

  // drop valid, wait for all pending results, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_frame();
    int               sel;
    int               cap;
    int               n;
    logic [BYTE_W-1:0] ty;
    logic [LEN_W-1:0]  len;
    // usually realign to a header so most frames are well formed
    if (hdr_count != 2'd0 && $urandom_range(0, 3) != 0 &&
        (hdr_count != 2'd3 || cur_len - pay_count <= 16'd64)) begin
      while (hdr_count != 2'd0) send_byte(8'($urandom), 1'b0, NO_RESULT);
    end
    sel = $urandom_range(0, 99);
    cap = (cfg_max_len < 16'd6) ? int'(cfg_max_len) : 6;
    if ($urandom_range(0, 19) == 0) cap = (cfg_max_len < 16'd40) ? int'(cfg_max_len) : 40;
    len = 16'($urandom_range(0, cap));
    ty  = cfg_pkt_type;
    if (sel < 10) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom), 1'b0, NO_RESULT);
      return;
    end
    if (sel >= 55 && sel < 70) begin
      ty = pick_type(1'b1);
    end else if (sel >= 70 && sel < 80) begin
      ty  = pick_type(1'b0);
      len = 16'($urandom);
    end else if (sel >= 80 && sel < 90 && cfg_max_len != 16'hFFFF) begin
      if ($urandom_range(0, 1) == 1) ty = pick_type(1'b1);
      len = (cfg_max_len > 16'hFFF0) ? 16'hFFFF : cfg_max_len + 16'($urandom_range(1, 3));
    end
    send_byte(ty, 1'b0, NO_RESULT);
    send_byte(len[7:0], 1'b0, NO_RESULT);
    send_byte(len[15:8], 1'b0, NO_RESULT);
    n = len;
    if ($urandom_range(0, 19) == 0) n = $urandom_range(0, int'(len));
    for (int i = 0; i < n && hdr_count == 2'd3; i++) send_byte(8'($urandom), 1'b0, NO_RESULT);
  endtask

  initial begin
    int stall_left;
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stalls_on && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("beat with nothing pending, kind", 16'(out_ch.kind), 16'(KIND_ERROR));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.kind !== want.kind)
          report("kind", 16'(out_ch.kind), 16'(want.kind));
        if (out_ch.data_out !== want.data_out)
          report("data_out", 16'(out_ch.data_out), 16'(want.data_out));
        if (out_ch.frame_length !== want.frame_length)
          report("frame_length", out_ch.frame_length, want.frame_length);
        if (out_ch.last_byte !== want.last_byte)
          report("last_byte", 16'(out_ch.last_byte), 16'(want.last_byte));
        if (out_ch.error_code !== want.error_code)
          report("error_code", 16'(out_ch.error_code), 16'(want.error_code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] pkt;
    logic [MASK_W-1:0] mask;
    logic [LEN_W-1:0]  maxlen;
    int unsigned       phase_no;
    int unsigned       phase_end;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_PACKET_TYPE;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    mismatches      = 0;
    sent_bytes      = 0;
    cycle_count     = 0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    quiet           = 1'b0;
    cfg_pkt_type    = RST_PACKET_TYPE;
    cfg_type_mask   = RST_KNOWN_MASK;
    cfg_max_len     = RST_MAX_PAYLOAD;
    clear_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_COUNT; i++) begin
      if (i == GROUP_B_AT) begin
        settle();
        write_reg(CFG_PACKET_TYPE, 64'h3F);
        write_reg(CFG_KNOWN_MASK, '1);
        write_reg(CFG_MAX_PAYLOAD, 64'd1);
      end
      send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
    end

    phase_no = 0;
    while (sent_bytes < BYTE_BUDGET) begin
      settle();
      case (phase_no)
        0: begin
          pkt = 8'hFF; mask = '1; maxlen = 16'd0;
        end
        1: begin
          pkt = 8'h00; mask = '0; maxlen = 16'hFFFF;
        end
        2: begin
          pkt = 8'd63; mask = '1; maxlen = 16'hFFFF;
        end
        default: begin
          pkt  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
          mask = {$urandom, $urandom};
          if (pkt < 8'd64 && $urandom_range(0, 5) != 0) mask[pkt[5:0]] = 1'b1;
          case ($urandom_range(0, 2))
            0:       maxlen = 16'($urandom_range(0, 8));
            1:       maxlen = 16'($urandom_range(8, 64));
            default: maxlen = 16'($urandom);
          endcase
        end
      endcase
      write_reg(CFG_PACKET_TYPE, 64'(pkt));
      write_reg(CFG_SPARE, {$urandom, $urandom});
      write_reg(CFG_KNOWN_MASK, mask);
      write_reg(CFG_MAX_PAYLOAD, 64'(maxlen));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      phase_end = sent_bytes + $urandom_range(100, 200);
      while (sent_bytes < phase_end && sent_bytes < BYTE_BUDGET) send_random_frame();
      phase_no++;
    end

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
